// File: design/pps_pkg.sv
// Package for the preemptive priority scheduler core.
// Holds field widths, command codes and the structs passed between the top level and cells.
// No dependencies.
package pps_pkg;

  localparam int DEFAULT_MAX_JOBS = 16;

  localparam int CMD_W   = 1;
  localparam int SLOT_W  = 4;
  localparam int BURST_W = 16;
  localparam int ARRV_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 20;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // Load word broadcast to every cell
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] burst;
    logic [ARRV_W-1:0]  arrival;
    logic [PRIO_W-1:0]  prio;
  } load_t;

  // Best candidate handed from cell to cell
  typedef struct packed {
    logic               found;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] burst;
    logic [ARRV_W-1:0]  arrival;
  } cand_t;

endpackage

// File: design/pps_if.sv
// Valid/ready channel interfaces for the scheduler's command and result words.
// Depends on pps_pkg for field widths.
interface pps_in_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_W-1:0]  job_slot;
  logic [BURST_W-1:0] burst_time;
  logic [ARRV_W-1:0]  arrival_time;
  logic [PRIO_W-1:0]  job_priority;

  modport source (output valid, command, job_slot, burst_time, arrival_time, job_priority,
                  input ready);
  modport sink   (input valid, command, job_slot, burst_time, arrival_time, job_priority,
                  output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              running_valid;
  logic [SLOT_W-1:0] running_slot;
  logic              finished_valid;
  logic [SLOT_W-1:0] finished_slot;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic              all_done;
  logic [TIME_W-1:0] current_time;

  modport source (output valid, running_valid, running_slot, finished_valid, finished_slot,
                  turnaround, waiting, all_done, current_time, input ready);
  modport sink   (input valid, running_valid, running_slot, finished_valid, finished_slot,
                  turnaround, waiting, all_done, current_time, output ready);
endinterface

// File: design/preemptive_priority_scheduler_core.sv
// Channel  | Dir | Word contents
// in_ch    | in  | command, job_slot, burst_time, arrival_time, job_priority
// out_ch   | out | running/finished flags and slots, turnaround, waiting, all_done, time
//
// A load word goes through ST_REPORT into the output register; a tick word goes through
// ST_SCAN, ST_FINISH, ST_REPORT; the candidate walks MAX_JOBS cells one cell a cycle.
// One word is in work at a time; a result waits in the output register while the next
// word is accepted. Reset (rst_n low, synchronous) clears all pending flags and time.
// A stalled output holds the finished result and the next result waits in the core.
module preemptive_priority_scheduler_core import pps_pkg::*; #(
  parameter int MAX_JOBS = DEFAULT_MAX_JOBS
) (
  input logic clk,
  input logic rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_REPORT
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  time_r;
  logic [TIME_W-1:0]  time_nxt;
  logic               res_run_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic               res_fin_r;
  logic [TIME_W-1:0]  res_tat_r;
  logic [TIME_W-1:0]  res_wt_r;
  logic               out_valid_r;
  logic               out_run_r;
  logic [SLOT_W-1:0]  out_run_slot_r;
  logic               out_fin_r;
  logic [SLOT_W-1:0]  out_fin_slot_r;
  logic [TIME_W-1:0]  out_tat_r;
  logic [TIME_W-1:0]  out_wt_r;
  logic               out_done_r;
  logic [TIME_W-1:0]  out_time_r;

  logic               accept;
  load_t              load;
  logic               run_en;
  cand_t              best;
  logic [IDX_W-1:0]   best_slot;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  wt;
  logic [MAX_JOBS-1:0] pending;

  cand_t              chain_c [MAX_JOBS+1];
  logic [IDX_W-1:0]   chain_s [MAX_JOBS+1];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Broadcast a load word to the cells
  assign load = '{we: accept && (in_ch.command == CMD_LOAD), slot: in_ch.job_slot,
                  burst: in_ch.burst_time, arrival: in_ch.arrival_time,
                  prio: in_ch.job_priority};

  // Chain head starts with no candidate
  assign chain_c[0] = '0;
  assign chain_s[0] = '0;

  generate
    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      pps_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .run_en     (run_en),
        .run_slot   (best_slot),
        .time_now   (time_r),
        .cand_in    (chain_c[i]),
        .slot_in    (chain_s[i]),
        .cand_out_r (chain_c[i+1]),
        .slot_out_r (chain_s[i+1]),
        .pending_r  (pending[i])
      );
    end
  endgenerate

  assign best      = chain_c[MAX_JOBS];
  assign best_slot = chain_s[MAX_JOBS];
  assign run_en    = (state_r == ST_FINISH) && best.found;

  // Advance time with saturation, derive turnaround and waiting
  assign time_nxt = (time_r == TIME_MAX) ? time_r : time_r + TIME_W'(1);
  assign tat      = time_nxt - TIME_W'(best.arrival);
  assign wt       = (tat > TIME_W'(best.burst)) ? tat - TIME_W'(best.burst) : '0;

  // Sequence one word at a time and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_REPORT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            res_run_r  <= 1'b0;
            res_slot_r <= '0;
            res_fin_r  <= 1'b0;
            res_tat_r  <= '0;
            res_wt_r   <= '0;
            cnt_r      <= '0;
            state_r    <= (in_ch.command == CMD_TICK) ? ST_SCAN : ST_REPORT;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(MAX_JOBS - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          time_r <= time_nxt;
          if (best.found) begin
            res_run_r  <= 1'b1;
            res_slot_r <= SLOT_W'(best_slot);
            if (best.rem == BURST_W'(1)) begin
              res_fin_r <= 1'b1;
              res_tat_r <= tat;
              res_wt_r  <= wt;
            end
          end
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r    <= 1'b1;
            out_run_r      <= res_run_r;
            out_run_slot_r <= res_slot_r;
            out_fin_r      <= res_fin_r;
            out_fin_slot_r <= res_fin_r ? res_slot_r : '0;
            out_tat_r      <= res_tat_r;
            out_wt_r       <= res_wt_r;
            out_done_r     <= ~|pending;
            out_time_r     <= time_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.running_valid  = out_run_r;
  assign out_ch.running_slot   = out_run_slot_r;
  assign out_ch.finished_valid = out_fin_r;
  assign out_ch.finished_slot  = out_fin_slot_r;
  assign out_ch.turnaround     = out_tat_r;
  assign out_ch.waiting        = out_wt_r;
  assign out_ch.all_done       = out_done_r;
  assign out_ch.current_time   = out_time_r;

endmodule

// File: design/pps_cell.sv
// One job slot of the scheduler chain: holds the slot's job and compares it against
// the candidate from the previous cell. Depends on pps_pkg.
module pps_cell import pps_pkg::*; #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  load_t             load,
  input  logic              run_en,
  input  logic [IDX_W-1:0]  run_slot,
  input  logic [TIME_W-1:0] time_now,
  input  cand_t             cand_in,
  input  logic [IDX_W-1:0]  slot_in,
  output cand_t             cand_out_r,
  output logic [IDX_W-1:0]  slot_out_r,
  output logic              pending_r
);

  logic [BURST_W-1:0] burst_r;
  logic [ARRV_W-1:0]  arrival_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [BURST_W-1:0] rem_r;
  logic               load_hit;
  logic               run_hit;
  logic               ready_now;
  logic               take_own;

  assign load_hit = load.we && (32'(load.slot) == 32'(CELL_IDX));
  assign run_hit  = run_en && (run_slot == IDX_W'(CELL_IDX));

  // Store job fields, count down remaining time when run
  always_ff @(posedge clk) begin
    if (load_hit) begin
      burst_r   <= load.burst;
      arrival_r <= load.arrival;
      prio_r    <= load.prio;
      rem_r     <= load.burst;
    end else if (run_hit) begin
      rem_r <= rem_r - BURST_W'(1);
    end
  end

  // Track pending: set by a nonzero load, drop on the last unit of work
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (load_hit) begin
      pending_r <= (load.burst != '0);
    end else if (run_hit && rem_r == BURST_W'(1)) begin
      pending_r <= 1'b0;
    end
  end

  // Take the candidate when arrived and better; prio ties go to shorter rem, then lower slot
  assign ready_now = pending_r && (TIME_W'(arrival_r) <= time_now);
  assign take_own  = ready_now && (!cand_in.found || prio_r < cand_in.prio ||
                     (prio_r == cand_in.prio && rem_r < cand_in.rem));

  // Hand the winner to the next cell
  always_ff @(posedge clk) begin
    if (take_own) begin
      cand_out_r <= '{found: 1'b1, prio: prio_r, rem: rem_r, burst: burst_r,
                      arrival: arrival_r};
      slot_out_r <= IDX_W'(CELL_IDX);
    end else begin
      cand_out_r <= cand_in;
      slot_out_r <= slot_in;
    end
  end

endmodule
